// ===== src/lfu_pkg.sv =====
// Shared constants, command/status types for the LFU page replacement block.
package lfu_pkg;

  localparam int FRAMES_DEF     = 8;
  localparam int PAGE_BITS_DEF  = 16;
  localparam int COUNT_BITS_DEF = 16;

  localparam int CFG_W       = 4;
  localparam int REF_W       = 32;
  localparam int FAULT_W     = 32;
  localparam int FRAME_OUT_W = 3;

  localparam logic [CFG_W-1:0] FRAMES_IN_USE_RST = 4'd8;

  // Where the frame being written comes from
  typedef enum logic [1:0] {
    SEL_HIT,
    SEL_EMPTY,
    SEL_VICTIM
  } sel_src_e;

  typedef struct packed {
    logic     load;       // latch the request page
    logic     best_init;  // seed the victim search with frame 0
    logic     scan_step;  // compare one more frame against the best so far
    logic     commit;     // update the chosen frame and issue the result
    sel_src_e src;
  } lfu_cmd_t;

  typedef struct packed {
    logic hit;
    logic has_empty;
    logic one_frame;
    logic scan_done;
  } lfu_stat_t;

endpackage

// ===== src/lfu_ctrl.sv =====
// Sequencer: lookup, optional victim scan, commit.
module lfu_ctrl
  import lfu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  lfu_stat_t stat_i,
  output lfu_cmd_t  cmd_o,
  output logic      busy_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LOOKUP = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_VICTIM = 2'd3;

  logic [1:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    cmd_o.load      = 1'b0;
    cmd_o.best_init = 1'b0;
    cmd_o.scan_step = 1'b0;
    cmd_o.commit    = 1'b0;
    cmd_o.src       = SEL_HIT;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (stat_i.hit) begin
          cmd_o.commit = 1'b1;
          cmd_o.src    = SEL_HIT;
          state_d      = S_IDLE;
        end else if (stat_i.has_empty) begin
          cmd_o.commit = 1'b1;
          cmd_o.src    = SEL_EMPTY;
          state_d      = S_IDLE;
        end else begin
          cmd_o.best_init = 1'b1;
          state_d         = stat_i.one_frame ? S_VICTIM : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_done) begin
          state_d = S_VICTIM;
        end
      end
      S_VICTIM: begin
        cmd_o.commit = 1'b1;
        cmd_o.src    = SEL_VICTIM;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

  a_lookup_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOOKUP) |-> $past(start_i))
    else $error("lookup entered without a start");

  a_scan_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> ($past(state_q) == S_LOOKUP || $past(state_q) == S_SCAN))
    else $error("scan entered from wrong state");

endmodule

// ===== src/lfu_dp.sv =====
// Frame table, tag compare, victim scan, counters and result registers.
module lfu_dp
  import lfu_pkg::*;
#(
  parameter int FRAMES     = FRAMES_DEF,
  parameter int PAGE_BITS  = PAGE_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lfu_cmd_t               cmd_i,
  output lfu_stat_t              stat_o,
  input  logic [PAGE_BITS-1:0]   page_i,
  input  logic                   cfg_valid_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  output logic                   valid_o,
  output logic                   hit_o,
  output logic [FRAME_OUT_W-1:0] frame_index_o,
  output logic                   evicted_valid_o,
  output logic [PAGE_BITS-1:0]   evicted_page_o,
  output logic [FAULT_W-1:0]     fault_total_o
);

  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int KEY_W = COUNT_BITS + REF_W;
  localparam int CMP_W = IDX_W + 5;

  logic [CFG_W-1:0]      cfg_q;
  logic [PAGE_BITS-1:0]  req_page_q;
  logic [FRAMES-1:0]     valid_q;
  logic [PAGE_BITS-1:0]  page_q    [FRAMES];
  logic [COUNT_BITS-1:0] uses_q    [FRAMES];
  logic [REF_W-1:0]      arrival_q [FRAMES];
  logic [REF_W-1:0]      ref_idx_q;
  logic [FAULT_W-1:0]    fault_q;

  logic [IDX_W-1:0]     scan_idx_q;
  logic [IDX_W-1:0]     best_idx_q;
  logic [KEY_W-1:0]     best_key_q;
  logic [PAGE_BITS-1:0] best_page_q;

  logic                 res_valid_q;
  logic                 res_hit_q;
  logic [FRAME_OUT_W-1:0] res_frame_q;
  logic                 res_ev_valid_q;
  logic [PAGE_BITS-1:0] res_ev_page_q;

  logic [CFG_W-1:0]  eff;
  logic [FRAMES-1:0] active;
  logic [FRAMES-1:0] hit_vec;
  logic [FRAMES-1:0] empty_vec;
  logic [IDX_W-1:0]  hit_idx;
  logic [IDX_W-1:0]  empty_idx;
  logic [IDX_W-1:0]  sel_idx;
  logic [KEY_W-1:0]  lane_key;

  function automatic logic [IDX_W-1:0] first_set(input logic [FRAMES-1:0] v);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int k = FRAMES - 1; k >= 0; k--) begin
      if (v[k]) r = IDX_W'(k);
    end
    return r;
  endfunction

  // A count of zero behaves as one; counts past FRAMES simply leave no extra lanes.
  assign eff = (cfg_q == '0) ? CFG_W'(1) : cfg_q;

  always_comb begin
    for (int j = 0; j < FRAMES; j++) begin
      active[j]    = (j < int'(eff));
      hit_vec[j]   = active[j] && valid_q[j] && (page_q[j] == req_page_q);
      empty_vec[j] = active[j] && !valid_q[j];
    end
  end

  assign hit_idx   = first_set(hit_vec);
  assign empty_idx = first_set(empty_vec);

  assign stat_o.hit       = |hit_vec;
  assign stat_o.has_empty = |empty_vec;
  assign stat_o.one_frame = (eff == CFG_W'(1)) || (FRAMES == 1);
  assign stat_o.scan_done = (CMP_W'(scan_idx_q) + CMP_W'(1) >= CMP_W'(eff)) ||
                            (scan_idx_q == IDX_W'(FRAMES - 1));

  assign lane_key = {uses_q[scan_idx_q], arrival_q[scan_idx_q]};

  always_comb begin
    unique case (cmd_i.src)
      SEL_HIT:    sel_idx = hit_idx;
      SEL_EMPTY:  sel_idx = empty_idx;
      SEL_VICTIM: sel_idx = best_idx_q;
      default:    sel_idx = best_idx_q;
    endcase
  end

  // Control-side state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= FRAMES_IN_USE_RST;
      valid_q     <= '0;
      ref_idx_q   <= '0;
      fault_q     <= '0;
      res_valid_q <= 1'b0;
      for (int j = 0; j < FRAMES; j++) begin
        uses_q[j] <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        cfg_q <= cfg_data_i;
      end
      res_valid_q <= cmd_i.commit;
      if (cmd_i.commit) begin
        if (ref_idx_q != '1) ref_idx_q <= ref_idx_q + REF_W'(1);
        if (cmd_i.src != SEL_HIT && fault_q != '1) fault_q <= fault_q + FAULT_W'(1);
        for (int j = 0; j < FRAMES; j++) begin
          if (sel_idx == IDX_W'(j)) begin
            if (cmd_i.src == SEL_HIT) begin
              if (uses_q[j] != '1) uses_q[j] <= uses_q[j] + COUNT_BITS'(1);
            end else begin
              uses_q[j]  <= COUNT_BITS'(1);
              valid_q[j] <= 1'b1;
            end
          end
        end
      end
    end
  end

  // Payload storage
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_page_q <= page_i;
    end
    if (cmd_i.best_init) begin
      best_idx_q  <= '0;
      best_key_q  <= {uses_q[0], arrival_q[0]};
      best_page_q <= page_q[0];
      scan_idx_q  <= IDX_W'(1);
    end else if (cmd_i.scan_step) begin
      // strict less keeps the earlier lane on a full tie
      if (lane_key < best_key_q) begin
        best_idx_q  <= scan_idx_q;
        best_key_q  <= lane_key;
        best_page_q <= page_q[scan_idx_q];
      end
      scan_idx_q <= scan_idx_q + IDX_W'(1);
    end
    if (cmd_i.commit) begin
      res_hit_q      <= (cmd_i.src == SEL_HIT);
      res_frame_q    <= FRAME_OUT_W'(sel_idx);
      res_ev_valid_q <= (cmd_i.src == SEL_VICTIM);
      res_ev_page_q  <= (cmd_i.src == SEL_VICTIM) ? best_page_q : '0;
      for (int j = 0; j < FRAMES; j++) begin
        if (sel_idx == IDX_W'(j) && cmd_i.src != SEL_HIT) begin
          page_q[j]    <= req_page_q;
          arrival_q[j] <= ref_idx_q;
        end
      end
    end
  end

  assign valid_o         = res_valid_q;
  assign hit_o           = res_hit_q;
  assign frame_index_o   = res_frame_q;
  assign evicted_valid_o = res_ev_valid_q;
  assign evicted_page_o  = res_ev_page_q;
  assign fault_total_o   = fault_q;

  a_evict_not_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_ev_valid_q) |-> !res_hit_q)
    else $error("eviction reported on a hit");

  a_fault_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_hit_q) |-> (fault_q != $past(fault_q) || fault_q == '1))
    else $error("fault total did not advance on a fault");

endmodule

// ===== src/lfu_page_replacement.sv =====
// LFU page replacement with FIFO tie-break: top level.
//
// Usage: drive page_i and pulse start_i; the reference is taken at a rising
// edge with start_i high and busy_o low. busy_o stays high until the result
// has been produced. Each reference yields one result, shown for exactly one
// cycle with valid_o high: hit_o, frame_index_o, evicted_valid_o,
// evicted_page_o and fault_total_o (fault_total_o holds until the next fault).
// The receiver cannot stall; results must be taken in that cycle.
// Flow: a hit, or a fault that fills an empty active frame, commits straight
// from the lookup, and the result registers are loaded at the commit edge. A
// fault with all active frames full runs a victim scan that compares one frame
// per cycle over the active frames (none with one active frame), then commits.
// Config: the frames_in_use register is written through cfg_valid_i /
// cfg_data_i (cfg_ready_o is always high); the user must write it only while
// the block is idle, and the block itself does not enforce this.
// Reset: all frames empty, use counts, reference index and fault total zero,
// frames_in_use = 8.
module lfu_page_replacement
  import lfu_pkg::*;
#(
  parameter int FRAMES     = FRAMES_DEF,
  parameter int PAGE_BITS  = PAGE_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic [PAGE_BITS-1:0]   page_i,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_W-1:0]       cfg_data_i,
  output logic                   valid_o,
  output logic                   hit_o,
  output logic [FRAME_OUT_W-1:0] frame_index_o,
  output logic                   evicted_valid_o,
  output logic [PAGE_BITS-1:0]   evicted_page_o,
  output logic [FAULT_W-1:0]     fault_total_o
);

  lfu_cmd_t  cmd;
  lfu_stat_t stat;

  assign cfg_ready_o = 1'b1;

  lfu_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  lfu_dp #(
    .FRAMES     (FRAMES),
    .PAGE_BITS  (PAGE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .page_i          (page_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_data_i      (cfg_data_i),
    .valid_o         (valid_o),
    .hit_o           (hit_o),
    .frame_index_o   (frame_index_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_page_o  (evicted_page_o),
    .fault_total_o   (fault_total_o)
  );

endmodule
